### hw/rtl/sptl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sptl_pkg
// Shared types and fixed field widths for the spectral peak track labeller.
// ----------------------------------------------------------------------------
package sptl_pkg;

  // fixed field widths
  localparam int FREQ_W     = 20;
  localparam int OUT_TRACK_W = 16;

  // reset value of the match threshold, 3.0 Hz in 1/16 Hz units
  localparam logic [FREQ_W-1:0] THRESHOLD_RESET = 20'd48;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FLUSH  = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

endpackage

### hw/rtl/spectral_peak_track_labeller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_peak_track_labeller_unit
// Nearest-frequency peak tracker: labels each peak with a track number.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one peak or a bare frame
//   boundary per beat; output channel (out_valid / out_stall) returns one
//   beat per item with peak_valid set, none for a bare boundary.
//   an item with a peak is compared against the N peaks held from the
//   previous frame (1..MAX_PEAKS): the scan state reads the stored entries
//   from the frame memory one entry a cycle, the flush state compares the
//   last entry, and the decision state loads the label. with no peaks
//   held, or on restart, it goes straight to the decision state.
//   in_stall is high until a peak's result is loaded; the next item is taken
//   as soon as the previous result sits in the output register.
//   if the receiver stalls, the finished result holds in the output register
//   and a following peak waits in its decision cycle until that beat goes.
//   reset clears frame counts, the track counter and the output valid, and
//   loads the match threshold with 48 (3.0 Hz); frame memory is not cleared,
//   only entries below the stored counts are ever read.
//   user writes threshold via cfg_write_en/data only while idle; not enforced.
// ----------------------------------------------------------------------------
module spectral_peak_track_labeller_unit
  import sptl_pkg::*;
#(
  parameter int MAX_PEAKS  = 64,
  parameter int TRACK_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_write_en,
  input  logic [FREQ_W-1:0]      cfg_write_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FREQ_W-1:0]      peak_freq,
  input  logic                   peak_valid,
  input  logic                   last_in_frame,
  input  logic                   restart,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_TRACK_W-1:0] track_id,
  output logic                   is_new_track,
  output logic                   ids_exhausted
);

  localparam int IDX_W   = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
  localparam int CNT_W   = $clog2(MAX_PEAKS + 1);
  localparam int ENTRY_W = FREQ_W + TRACK_BITS;

  // frame memory: two banks, one holds the previous frame, the other the
  // frame being built; a frame end just swaps them
  logic [ENTRY_W-1:0] frame_mem [2][MAX_PEAKS];

  state_t                state;
  logic [FREQ_W-1:0]     match_threshold;
  logic                  prev_bank;
  logic [CNT_W-1:0]      prev_count;
  logic [CNT_W-1:0]      cur_count;
  logic [TRACK_BITS:0]   next_track;

  // item being labelled
  logic [FREQ_W-1:0]     item_freq;
  logic                  item_last;

  // scan
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_pending;
  logic [ENTRY_W-1:0]    rd_data;
  logic                  found;
  logic [FREQ_W-1:0]     best_diff;
  logic [TRACK_BITS-1:0] best_track;

  // output register
  logic [31:0]           out_track_wide;
  logic [TRACK_BITS-1:0] out_track;

  logic                  in_accept;
  logic                  out_free;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // compare the entry that came out of memory against the item
  logic [FREQ_W-1:0]     rd_freq;
  logic [TRACK_BITS-1:0] rd_track;
  logic [FREQ_W-1:0]     diff;
  logic                  better;

  assign rd_freq  = rd_data[ENTRY_W-1:TRACK_BITS];
  assign rd_track = rd_data[TRACK_BITS-1:0];
  assign diff     = (rd_freq > item_freq) ? (rd_freq - item_freq) : (item_freq - rd_freq);
  // strict compare keeps the earliest entry on a tie
  assign better   = (diff < match_threshold) && (!found || (diff < best_diff));

  // decision for the item
  logic                  last_issue;
  logic [TRACK_BITS-1:0] label_track;
  logic                  label_fresh;
  logic [TRACK_BITS:0]   next_track_next;

  assign last_issue = ((CNT_W'(rd_idx) + CNT_W'(1)) == prev_count);

  always_comb begin
    next_track_next = next_track;
    if (found) begin
      label_track = best_track;
      label_fresh = 1'b0;
    end else if (next_track[TRACK_BITS]) begin
      // counter saturated: hand out the top number again
      label_track = '1;
      label_fresh = 1'b1;
    end else begin
      label_track     = next_track[TRACK_BITS-1:0];
      label_fresh     = 1'b1;
      next_track_next = next_track + (TRACK_BITS+1)'(1);
    end
  end

  assign out_track_wide = 32'(out_track);
  assign track_id       = out_track_wide[OUT_TRACK_W-1:0];

  // memory ports
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      rd_data <= frame_mem[prev_bank][rd_idx];
    end
    if ((state == ST_DECIDE) && out_free && (cur_count < CNT_W'(MAX_PEAKS))) begin
      frame_mem[!prev_bank][cur_count[IDX_W-1:0]] <= {item_freq, label_track};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      match_threshold <= THRESHOLD_RESET;
      prev_bank       <= 1'b0;
      prev_count      <= '0;
      cur_count       <= '0;
      next_track      <= '0;
      rd_pending      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        match_threshold <= cfg_write_data;
      end

      // a beat leaving while a new label is loaded is handled in ST_DECIDE
      if (out_valid && !out_stall && (state != ST_DECIDE)) begin
        out_valid <= 1'b0;
      end

      rd_pending <= (state == ST_SCAN);
      if (rd_pending && better) begin
        found      <= 1'b1;
        best_diff  <= diff;
        best_track <= rd_track;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            item_freq <= peak_freq;
            item_last <= last_in_frame;
            found     <= 1'b0;
            rd_idx    <= '0;
            if (restart) begin
              next_track <= '0;
              cur_count  <= '0;
              prev_count <= '0;
            end
            if (peak_valid) begin
              if (restart || (prev_count == '0)) begin
                state <= ST_DECIDE;
              end else begin
                state <= ST_SCAN;
              end
            end else if (last_in_frame) begin
              // bare boundary closes the frame
              prev_bank  <= !prev_bank;
              prev_count <= restart ? '0 : cur_count;
              cur_count  <= '0;
            end
          end
        end
        ST_SCAN: begin
          // one read per cycle over the previous frame
          if (last_issue) begin
            state <= ST_FLUSH;
          end else begin
            rd_idx <= rd_idx + IDX_W'(1);
          end
        end
        ST_FLUSH: begin
          // last entry is compared in this cycle
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_track     <= label_track;
            is_new_track  <= label_fresh;
            ids_exhausted <= next_track_next[TRACK_BITS];
            next_track    <= next_track_next;
            if (item_last) begin
              prev_bank  <= !prev_bank;
              prev_count <= (cur_count < CNT_W'(MAX_PEAKS)) ?
                            cur_count + CNT_W'(1) : cur_count;
              cur_count  <= '0;
            end else if (cur_count < CNT_W'(MAX_PEAKS)) begin
              cur_count <= cur_count + CNT_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
